@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cda_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar date day adder.
// No dependencies.
package cda_pkg;

  localparam int unsigned AddWidth   = 16;
  localparam int unsigned SumWidth   = AddWidth + 1;
  localparam int unsigned DayWidth   = 5;
  localparam int unsigned MonWidth   = 4;
  localparam int unsigned YearWidth  = 12;
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  localparam logic [YearWidth-1:0] YearMinReset = 12'd1900;
  localparam logic [YearWidth-1:0] YearMaxReset = 12'd2100;
  localparam logic [YearWidth-1:0] YearLimit    = 12'd4095;

  localparam logic [DayWidth-1:0] LeapFebDays = 5'd29;
  localparam logic [DayWidth-1:0] DayLast     = 5'd31;

  localparam logic [MonWidth-1:0] MonthJan = 4'd1;
  localparam logic [MonWidth-1:0] MonthFeb = 4'd2;
  localparam logic [MonWidth-1:0] MonthDec = 4'd12;

  // Register indexes (paddr[2]).
  localparam logic RegIdxYearMin = 1'b0;
  localparam logic RegIdxYearMax = 1'b1;

  // floor(y / 100) = (y * Div100Mul) >> Div100Shift, exact for 12-bit y.
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdWidth   = YearWidth + 13;
  localparam int unsigned CentWidth   = 6;

  localparam logic [6:0] YearsPerCent = 7'd99;

  typedef struct packed {
    logic [YearWidth-1:0] year_min;
    logic [YearWidth-1:0] year_max;
  } cda_cfg_t;

  typedef enum logic [1:0] {
    StIdle,
    StSplit,
    StCheck,
    StWalk
  } cda_state_e;

  // Days in a month; zero for a month code outside 1 to 12.
  function automatic logic [DayWidth-1:0] month_days(input logic [MonWidth-1:0] mon,
                                                     input logic leap);
    logic [DayWidth-1:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? LeapFebDays : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/cda_cfg_regs.sv @@
// APB-style register file holding the accepted year bounds.
// Depends on cda_pkg.
module cda_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cda_pkg::PaddrWidth-1:0]       paddr,
  input  logic [cda_pkg::PdataWidth-1:0]       pwdata,
  output logic [cda_pkg::PdataWidth-1:0]       prdata,
  output logic                                 pready,
  output cda_pkg::cda_cfg_t                    cfg_o
);
  import cda_pkg::*;

  logic [YearWidth-1:0] year_min_q, year_min_d;
  logic [YearWidth-1:0] year_max_q, year_max_d;
  logic                 wr_en;
  logic [YearWidth-1:0] rd_sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    year_min_d = year_min_q;
    year_max_d = year_max_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegIdxYearMin: year_min_d = pwdata[YearWidth-1:0];
        RegIdxYearMax: year_max_d = pwdata[YearWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegIdxYearMin: rd_sel = year_min_q;
      RegIdxYearMax: rd_sel = year_max_q;
      default:       rd_sel = '0;
    endcase
  end

  assign prdata = {{(PdataWidth-YearWidth){1'b0}}, rd_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_min_q <= YearMinReset;
      year_max_q <= YearMaxReset;
    end else begin
      year_min_q <= year_min_d;
      year_max_q <= year_max_d;
    end
  end

  assign cfg_o.year_min = year_min_q;
  assign cfg_o.year_max = year_max_q;

endmodule

@@ hw/rtl/calendar_date_day_adder.sv @@
// Gregorian date plus day count. One transaction in, one transaction out. After an input
// transaction is taken, the block computes the century of the year (StSplit), checks the
// date and registers the year-of-century (StCheck), then walks one month per step (StWalk)
// until the remaining day count fits the current month or the result saturates at 31 Dec
// 4095; an invalid date is echoed unchanged from StCheck. The month walk runs on a single
// subtract-and-compare unit; the input is not ready again until the result has been loaded
// into the output register. Year bounds sit in an APB-style register file at byte 0
// (year_min) and byte 4 (year_max). Depends on cda_pkg and cda_cfg_regs.
module calendar_date_day_adder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cda_pkg::DayWidth-1:0]         start_day_i,
  input  logic [cda_pkg::MonWidth-1:0]         start_month_i,
  input  logic [cda_pkg::YearWidth-1:0]        start_year_i,
  input  logic [15:0]                          days_to_add_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cda_pkg::DayWidth-1:0]         result_day_o,
  output logic [cda_pkg::MonWidth-1:0]         result_month_o,
  output logic [cda_pkg::YearWidth-1:0]        result_year_o,
  output logic                                 date_valid_o,
  output logic                                 year_overflow_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cda_pkg::PaddrWidth-1:0]       paddr,
  input  logic [cda_pkg::PdataWidth-1:0]       pwdata,
  output logic [cda_pkg::PdataWidth-1:0]       prdata,
  output logic                                 pready
);
  import cda_pkg::*;

  cda_cfg_t cfg;

  cda_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cda_state_e state_q, state_d;

  // Working registers.
  logic [DayWidth-1:0]  day_q, day_d;
  logic [MonWidth-1:0]  mon_q, mon_d;
  logic [YearWidth-1:0] year_q, year_d;
  logic [SumWidth-1:0]  sum_q, sum_d;
  logic [CentWidth-1:0] cent_q, cent_d;
  logic [6:0]           ryear_q, ryear_d;
  logic [1:0]           cent4_q, cent4_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [DayWidth-1:0]  res_day_q, res_day_d;
  logic [MonWidth-1:0]  res_mon_q, res_mon_d;
  logic [YearWidth-1:0] res_year_q, res_year_d;
  logic                 res_dv_q, res_dv_d;
  logic                 res_ovf_q, res_ovf_d;

  logic                 in_fire, slot_free;
  logic [ProdWidth-1:0] cent_prod;
  logic [YearWidth-1:0] cent_x100, ryear_full;
  logic                 leap_chk, leap_walk;
  logic                 date_ok;
  logic [DayWidth-1:0]  len_chk, len_walk;
  logic                 walk_fits, walk_ovf;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;

  // Century split: reciprocal multiply, then remainder by constant shifts.
  assign cent_prod  = ProdWidth'(year_q) * ProdWidth'(Div100Mul);
  assign cent_x100  = (YearWidth'(cent_q) << 6) + (YearWidth'(cent_q) << 5)
                    + (YearWidth'(cent_q) << 2);
  assign ryear_full = year_q - cent_x100;

  assign leap_chk  = (ryear_full[6:0] == '0) ? (cent_q[1:0] == 2'd0) : (year_q[1:0] == 2'd0);
  assign leap_walk = (ryear_q == '0) ? (cent4_q == 2'd0) : (year_q[1:0] == 2'd0);

  assign len_chk  = month_days(mon_q, leap_chk);
  assign len_walk = month_days(mon_q, leap_walk);

  assign date_ok = (year_q >= cfg.year_min) && (year_q <= cfg.year_max)
                && (mon_q >= MonthJan) && (mon_q <= MonthDec)
                && (day_q != '0) && (day_q <= len_chk);

  assign walk_fits = (sum_q <= SumWidth'(len_walk));
  assign walk_ovf  = (mon_q == MonthDec) && (year_q == YearLimit);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StSplit;
      StSplit: state_d = StCheck;
      StCheck: begin
        if (date_ok) state_d = StWalk;
        else if (slot_free) state_d = StIdle;
      end
      StWalk: begin
        if ((walk_fits || walk_ovf) && slot_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    day_d       = day_q;
    mon_d       = mon_q;
    year_d      = year_q;
    sum_d       = sum_q;
    cent_d      = cent_q;
    ryear_d     = ryear_q;
    cent4_d     = cent4_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    res_day_d   = res_day_q;
    res_mon_d   = res_mon_q;
    res_year_d  = res_year_q;
    res_dv_d    = res_dv_q;
    res_ovf_d   = res_ovf_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          day_d  = start_day_i;
          mon_d  = start_month_i;
          year_d = start_year_i;
          sum_d  = SumWidth'(start_day_i) + SumWidth'(days_to_add_i[AddWidth-1:0]);
        end
      end
      StSplit: begin
        cent_d = cent_prod[Div100Shift +: CentWidth];
      end
      StCheck: begin
        ryear_d = ryear_full[6:0];
        cent4_d = cent_q[1:0];
        if (!date_ok && slot_free) begin
          // Echo the input untouched.
          out_valid_d = 1'b1;
          res_day_d   = day_q;
          res_mon_d   = mon_q;
          res_year_d  = year_q;
          res_dv_d    = 1'b0;
          res_ovf_d   = 1'b0;
        end
      end
      StWalk: begin
        if (walk_fits) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            res_day_d   = sum_q[DayWidth-1:0];
            res_mon_d   = mon_q;
            res_year_d  = year_q;
            res_dv_d    = 1'b1;
            res_ovf_d   = 1'b0;
          end
        end else if (walk_ovf) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            res_day_d   = DayLast;
            res_mon_d   = MonthDec;
            res_year_d  = YearLimit;
            res_dv_d    = 1'b1;
            res_ovf_d   = 1'b1;
          end
        end else begin
          // Consume this month and advance.
          sum_d = sum_q - SumWidth'(len_walk);
          if (mon_q == MonthDec) begin
            mon_d  = MonthJan;
            year_d = year_q + YearWidth'(1);
            if (ryear_q == YearsPerCent) begin
              ryear_d = '0;
              cent4_d = cent4_q + 2'd1;
            end else begin
              ryear_d = ryear_q + 7'd1;
            end
          end else begin
            mon_d = mon_q + MonWidth'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q      <= day_d;
    mon_q      <= mon_d;
    year_q     <= year_d;
    sum_q      <= sum_d;
    cent_q     <= cent_d;
    ryear_q    <= ryear_d;
    cent4_q    <= cent4_d;
    res_day_q  <= res_day_d;
    res_mon_q  <= res_mon_d;
    res_year_q <= res_year_d;
    res_dv_q   <= res_dv_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_day_o    = res_day_q;
  assign result_month_o  = res_mon_q;
  assign result_year_o   = res_year_q;
  assign date_valid_o    = res_dv_q;
  assign year_overflow_o = res_ovf_q;

endmodule

@@ hw/rtl/cda_checker.sv @@
// Port-level checks for the calendar date day adder, bound to the top level.
// Depends on cda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cda_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cda_pkg::DayWidth-1:0]  result_day_o,
  input logic [cda_pkg::MonWidth-1:0]  result_month_o,
  input logic [cda_pkg::YearWidth-1:0] result_year_o,
  input logic                          date_valid_o,
  input logic                          year_overflow_o
);
  import cda_pkg::*;

  `ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output transaction dropped")

  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")

  `ASSERT_CLK(a_ovf_saturates, clk_i, rst_ni, out_valid_o && year_overflow_o |-> date_valid_o && (result_day_o == DayLast) && (result_month_o == MonthDec) && (result_year_o == YearLimit), "overflow result not saturated")

  `ASSERT_CLK(a_valid_date_range, clk_i, rst_ni, out_valid_o && date_valid_o |-> (result_month_o >= MonthJan) && (result_month_o <= MonthDec) && (result_day_o != '0), "valid result out of range")

endmodule

bind calendar_date_day_adder cda_checker u_cda_checker (.*);

@@ dv/calendar_date_day_adder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_day_adder: drives start dates and day counts,
// predicts each resulting date and compares the results field by field.
// Depends on cda_pkg and the calendar_date_day_adder RTL.
module calendar_date_day_adder_tb;
  import cda_pkg::*;

  localparam int unsigned IdleLimit     = 20000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 10;

  localparam logic [PaddrWidth-1:0] AddrYearMin = {RegIdxYearMin, 2'b00};
  localparam logic [PaddrWidth-1:0] AddrYearMax = {RegIdxYearMax, 2'b00};

  typedef struct packed {
    logic [DayWidth-1:0]  day;
    logic [MonWidth-1:0]  month;
    logic [YearWidth-1:0] year;
    logic                 valid;
    logic                 overflow;
  } date_result_t;

  logic clk_i = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_ready;
  logic [DayWidth-1:0]   start_day;
  logic [MonWidth-1:0]   start_month;
  logic [YearWidth-1:0]  start_year;
  logic [15:0]           days_to_add;
  logic                  out_valid;
  logic                  out_ready;
  logic [DayWidth-1:0]   result_day;
  logic [MonWidth-1:0]   result_month;
  logic [YearWidth-1:0]  result_year;
  logic                  date_valid;
  logic                  year_overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  // Year bounds as the block should hold them.
  logic [YearWidth-1:0] bound_min = YearMinReset;
  logic [YearWidth-1:0] bound_max = YearMaxReset;

  date_result_t expected_dates[$];

  bit sender_gaps_on  = 1'b1;
  bit ready_stalls_on = 1'b1;
  bit hold_off_req    = 1'b0;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned n_sent, n_checked, n_invalid, n_overflow, n_settings;
  int unsigned n_errors;

  calendar_date_day_adder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .start_day_i     (start_day),
    .start_month_i   (start_month),
    .start_year_i    (start_year),
    .days_to_add_i   (days_to_add),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_day_o    (result_day),
    .result_month_o  (result_month),
    .result_year_o   (result_year),
    .date_valid_o    (date_valid),
    .year_overflow_o (year_overflow),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MonthFeb:              return is_leap_year(yr) ? LeapFebDays : 28;
      default:               return 0;
    endcase
  endfunction

  // Validate the start date, then walk month by month until the remainder fits.
  function automatic date_result_t predict_date_sum(input logic [DayWidth-1:0] d,
                                                    input logic [MonWidth-1:0] m,
                                                    input logic [YearWidth-1:0] y,
                                                    input logic [15:0] add);
    date_result_t r;
    int unsigned  rem, mon, yr;
    r = '{day: d, month: m, year: y, valid: 1'b0, overflow: 1'b0};
    if (y < bound_min || y > bound_max || m < MonthJan || m > MonthDec ||
        d == 0 || d > month_length(32'(m), 32'(y)))
      return r;
    r.valid = 1'b1;
    rem = d + (add & ((32'd1 << AddWidth) - 1));
    mon = 32'(m);
    yr  = 32'(y);
    while (!r.overflow && rem > month_length(mon, yr)) begin
      rem -= month_length(mon, yr);
      if (mon == MonthDec) begin
        mon = 32'(MonthJan);
        if (yr >= YearLimit) r.overflow = 1'b1;
        else yr++;
      end else begin
        mon++;
      end
    end
    if (r.overflow) begin
      r.day   = DayLast;
      r.month = MonthDec;
      r.year  = YearLimit;
    end else begin
      r.day   = DayWidth'(rem);
      r.month = MonWidth'(mon);
      r.year  = YearWidth'(yr);
    end
    return r;
  endfunction

  // Offer one date and hold it until the block takes it.
  task automatic send_date(input logic [DayWidth-1:0] d, input logic [MonWidth-1:0] m,
                           input logic [YearWidth-1:0] y, input logic [15:0] add);
    int unsigned gap;
    in_valid    <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    days_to_add <= add;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_dates.push_back(predict_date_sum(d, m, y, add));
    n_sent++;
    gap = 0;
    if (sender_gaps_on && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly short counts keep the walk brief; a few use the whole field.
  function automatic logic [15:0] pick_day_count();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return 16'($urandom_range(0, 400));
    if (sel < 18) return 16'($urandom_range(0, 5000));
    return 16'($urandom());
  endfunction

  task automatic send_random_date();
    logic [DayWidth-1:0]  d;
    logic [MonWidth-1:0]  m;
    logic [YearWidth-1:0] y;
    if (bound_min <= bound_max && $urandom_range(0, 4) != 0) begin
      y = YearWidth'($urandom_range(bound_min, bound_max));
      m = MonWidth'($urandom_range(MonthJan, MonthDec));
      if ($urandom_range(0, 4) == 0) d = DayWidth'(month_length(32'(m), 32'(y)));
      else d = DayWidth'($urandom_range(1, month_length(32'(m), 32'(y))));
    end else begin
      d = DayWidth'($urandom());
      m = MonWidth'($urandom());
      y = YearWidth'($urandom());
    end
    send_date(d, m, y, pick_day_count());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PaddrWidth-1:0] addr, input logic [YearWidth-1:0] value);
    logic [31:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {junk[31:YearWidth], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Call only with the block idle.
  task automatic set_year_bounds(input logic [YearWidth-1:0] lo, input logic [YearWidth-1:0] hi);
    apb_write(AddrYearMin, lo);
    apb_write(AddrYearMax, hi);
    bound_min = lo;
    bound_max = hi;
    n_settings++;
  endtask

  task automatic test_reset_bounds();
    send_date(5'd1, 4'd1, 12'd1900, 16'd0);
    send_date(5'd31, 4'd12, 12'd2100, 16'd1);
    send_date(5'd15, 4'd6, 12'd1899, 16'd5);
    send_date(5'd1, 4'd1, 12'd2101, 16'd0);
    send_date(5'd31, 4'd1, 12'd1900, 16'hFFFF);
    send_date(5'd31, 4'd1, 12'd2023, 16'd1);
  endtask

  task automatic test_leap_rules();
    send_date(5'd29, MonthFeb, 12'd2000, 16'd0);
    send_date(5'd29, MonthFeb, 12'd1900, 16'd0);
    send_date(5'd29, MonthFeb, 12'd2001, 16'd3);
    send_date(5'd28, MonthFeb, 12'd2024, 16'd1);
    send_date(5'd0, 4'd5, 12'd2020, 16'd7);
    send_date(5'd31, 4'd4, 12'd2020, 16'd7);
    send_date(5'd31, 4'd0, 12'd2050, 16'd10);
    send_date(5'd31, 4'd13, 12'd2050, 16'd10);
    send_date(5'd31, 4'd15, 12'd2050, 16'd10);
  endtask

  task automatic test_full_year_range();
    wait_idle();
    set_year_bounds(12'd0, 12'd4095);
    send_date(5'd29, MonthFeb, 12'd0, 16'd1);
    send_date(5'd31, MonthDec, 12'd4095, 16'd0);
    send_date(5'd31, MonthDec, 12'd4095, 16'd1);
    send_date(5'd1, MonthJan, 12'd4095, 16'hFFFF);
    send_date(5'd1, MonthJan, 12'd0, 16'hFFFF);
    send_date(5'd30, 4'd11, 12'd4094, 16'h8000);
  endtask

  task automatic test_crossed_bounds();
    wait_idle();
    set_year_bounds(12'd2000, 12'd1999);
    send_date(5'd1, MonthJan, 12'd2000, 16'd10);
    send_date(5'd31, MonthDec, 12'd1999, 16'd1);
    wait_idle();
    set_year_bounds(12'd2024, 12'd2024);
    send_date(5'd29, MonthFeb, 12'd2024, 16'd0);
    send_date(5'd31, MonthDec, 12'd2023, 16'd1);
  endtask

  // Hold the output off long enough that the block stalls its input.
  task automatic test_output_backpressure();
    wait_idle();
    set_year_bounds(YearMinReset, YearMaxReset);
    sender_gaps_on = 1'b0;
    hold_off_req   = 1'b1;
    repeat (8) send_random_date();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_dates(input logic [YearWidth-1:0] lo, input logic [YearWidth-1:0] hi,
                                   input int unsigned count);
    wait_idle();
    set_year_bounds(lo, hi);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        sender_gaps_on  = ($urandom_range(0, 3) != 0);
        ready_stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_random_date();
    end
    sender_gaps_on  = 1'b1;
    ready_stalls_on = 1'b1;
  endtask

  // Receiver: random short stalls, a few long ones, and the requested hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (ready_stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [YearWidth-1:0] want,
                             input logic [YearWidth-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result transaction with no date pending");
        n_errors++;
      end else begin
        want = expected_dates.pop_front();
        check_field("result_day", YearWidth'(want.day), YearWidth'(result_day));
        check_field("result_month", YearWidth'(want.month), YearWidth'(result_month));
        check_field("result_year", want.year, result_year);
        check_field("date_valid", YearWidth'(want.valid), YearWidth'(date_valid));
        check_field("year_overflow", YearWidth'(want.overflow), YearWidth'(year_overflow));
        n_checked++;
        if (!want.valid) n_invalid++;
        if (want.overflow) n_overflow++;
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    start_day   <= '0;
    start_month <= '0;
    start_year  <= '0;
    days_to_add <= '0;
    out_ready   <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_bounds();
    test_leap_rules();
    test_full_year_range();
    test_crossed_bounds();
    test_output_backpressure();
    test_random_dates(YearMinReset, YearMaxReset, 70);
    test_random_dates(12'd0, 12'd4095, 70);
    test_random_dates(12'd3990, 12'd4095, 50);
    begin
      logic [YearWidth-1:0] lo;
      lo = YearWidth'($urandom_range(0, 3000));
      test_random_dates(lo, YearWidth'($urandom_range(lo, 4095)), 50);
    end
    wait_idle();

    $display("Checked %0d of %0d date transactions under %0d year-bound settings:",
             n_checked, n_sent, n_settings + 1);
    $display("  %0d invalid start dates, %0d year overflows, %0d mismatches",
             n_invalid, n_overflow, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
